/* src/rcbp_pkg.sv */
// Shared constants, codes and types for the reference-counted buffer pool.
`default_nettype none

package rcbp_pkg;

    // Default pool size handed to the top level.
    localparam int DEF_BUFFERS = 16;

    // Fixed field widths of the ports and of the reference counters.
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Operation codes carried in the kind field.
    localparam logic [KIND_W-1:0] KIND_PUBLISH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    // Status codes returned with every result.
    localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY        = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_CURRENT   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_RELEASE_ZERO = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW     = 3'd4;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_PUB_SET,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

/* src/rcbp_count_ram.sv */
// Reference count memory: registered read, unwritten entries read as zero.
`default_nettype none

module rcbp_count_ram #(
    parameter int DEPTH = rcbp_pkg::DEF_BUFFERS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         rd_en,
    input  wire logic [ADDR_W-1:0]            rd_addr,
    output logic      [rcbp_pkg::COUNT_W-1:0] rd_data,
    input  wire logic                         wr_en,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [rcbp_pkg::COUNT_W-1:0] wr_data
);

    logic [rcbp_pkg::COUNT_W-1:0] mem [DEPTH];
    logic [rcbp_pkg::COUNT_W-1:0] data_reg;
    logic [DEPTH-1:0]             written_reg;
    logic                         hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem[rd_addr];
        end
    end

    // One written flag per entry stands in for clearing the array at reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                hit_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = hit_reg ? data_reg : '0;

endmodule

`default_nettype wire

/* src/rcbp_link_ram.sv */
// Free stack link memory: registered read, unwritten entries link to the next index.
`default_nettype none

module rcbp_link_ram #(
    parameter int DEPTH = rcbp_pkg::DEF_BUFFERS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [ADDR_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [ADDR_W-1:0] wr_data
);

    logic [ADDR_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] data_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DEPTH-1:0]  written_reg;
    logic              hit_reg;
    logic [ADDR_W-1:0] reset_link;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            data_reg <= mem[rd_addr];
            addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                hit_reg <= written_reg[rd_addr];
            end
        end
    end

    // After reset the stack is chained in index order, wrapping at the last entry.
    assign reset_link = (addr_reg == ADDR_W'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
    assign rd_data    = hit_reg ? data_reg : reset_link;

endmodule

`default_nettype wire

/* src/refcounted_buffer_pool.sv */
// Top level of the reference-counted buffer pool with its free stack and sequencer.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_kind, s_buffer_index
//  m_       out        m_valid / m_ready    m_granted_buffer, m_writer_buffer, m_status
//
// The accepting edge starts the synchronous read of the count and link memories, the execute
// state updates them, and a successful publish passes through the S_PUB_SET state for a
// second count write that gives the new current buffer its single reference, since the
// count memory has one write port. The result is loaded into the output register from the
// done state once that register is free, and the input is ready again once it is loaded, so
// the block takes no new transaction until the last one's result has been loaded.
// Reset is synchronous and active low; the memories need no clearing pass because each
// entry carries a written flag. A result waiting in the output register does not hold
// up the next transaction until that one's own result is ready to be loaded.
`default_nettype none

module refcounted_buffer_pool #(
    parameter int BUFFERS = rcbp_pkg::DEF_BUFFERS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rcbp_pkg::KIND_W-1:0]   s_kind,
    input  wire logic [rcbp_pkg::INDEX_W-1:0]  s_buffer_index,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [rcbp_pkg::INDEX_W-1:0]  m_granted_buffer,
    output logic      [rcbp_pkg::INDEX_W-1:0]  m_writer_buffer,
    output logic      [rcbp_pkg::STATUS_W-1:0] m_status
);

    localparam int IDX_W  = $clog2(BUFFERS);
    localparam int FCNT_W = $clog2(BUFFERS + 1);
    localparam int WIDE_W = IDX_W + rcbp_pkg::INDEX_W;

    // Sequencer state.
    rcbp_pkg::state_t state_reg, state_next;

    // Latched transaction.
    logic [rcbp_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic                        idx_ok_reg, idx_ok_next;

    // Pool state kept in registers.
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]  pend_reg, pend_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;

    // Result waiting to be loaded into the output register.
    logic [IDX_W-1:0]              res_granted_reg, res_granted_next;
    logic [rcbp_pkg::STATUS_W-1:0] res_status_reg, res_status_next;

    // Output register.
    logic                          m_valid_reg, m_valid_next;
    logic [rcbp_pkg::INDEX_W-1:0]  m_granted_reg, m_granted_next;
    logic [rcbp_pkg::INDEX_W-1:0]  m_writer_reg, m_writer_next;
    logic [rcbp_pkg::STATUS_W-1:0] m_status_reg, m_status_next;

    // Memory ports.
    logic                         mem_rd_en;
    logic [IDX_W-1:0]             cnt_rd_addr;
    logic [rcbp_pkg::COUNT_W-1:0] cnt_q;
    logic                         cnt_wr_en;
    logic [IDX_W-1:0]             cnt_wr_addr;
    logic [rcbp_pkg::COUNT_W-1:0] cnt_wr_data;
    logic [IDX_W-1:0]             link_q;
    logic                         link_wr_en;
    logic [IDX_W-1:0]             link_wr_addr;
    logic [IDX_W-1:0]             link_wr_data;

    // Decoded helpers.
    logic              s_accept;
    logic              out_free;
    logic              pub_ok;
    logic              stack_room;
    logic [WIDE_W-1:0] s_idx_wide;
    logic [WIDE_W-1:0] granted_wide;
    logic [WIDE_W-1:0] writer_wide;

    rcbp_count_ram #(
        .DEPTH(BUFFERS)
    ) u_count_ram (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd_en  (mem_rd_en),
        .rd_addr(cnt_rd_addr),
        .rd_data(cnt_q),
        .wr_en  (cnt_wr_en),
        .wr_addr(cnt_wr_addr),
        .wr_data(cnt_wr_data)
    );

    // The link read always looks at the stack head so a pop is ready during execution.
    rcbp_link_ram #(
        .DEPTH(BUFFERS)
    ) u_link_ram (
        .aclk   (aclk),
        .aresetn(aresetn),
        .rd_en  (mem_rd_en),
        .rd_addr(head_reg),
        .rd_data(link_q),
        .wr_en  (link_wr_en),
        .wr_addr(link_wr_addr),
        .wr_data(link_wr_data)
    );

    assign s_accept   = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign s_idx_wide = {{IDX_W{1'b0}}, s_buffer_index};
    assign stack_room = fcnt_reg < FCNT_W'(BUFFERS);

    // A publish goes ahead unless the stack is empty and the old current buffer
    // does not come free on this very publish.
    assign pub_ok = (fcnt_reg != '0)
                 || (cur_valid_reg && cnt_q == rcbp_pkg::COUNT_W'(1));

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rcbp_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = rcbp_pkg::S_EXEC;
                end
            end
            rcbp_pkg::S_EXEC: begin
                if (kind_reg == rcbp_pkg::KIND_PUBLISH && pub_ok) begin
                    state_next = rcbp_pkg::S_PUB_SET;
                end else begin
                    state_next = rcbp_pkg::S_DONE;
                end
            end
            rcbp_pkg::S_PUB_SET: begin
                state_next = rcbp_pkg::S_DONE;
            end
            rcbp_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = rcbp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rcbp_pkg::S_IDLE;
            end
        endcase
    end

    // Output and datapath logic.
    always_comb begin
        s_ready          = 1'b0;
        mem_rd_en        = 1'b0;
        cnt_rd_addr      = cur_reg;
        cnt_wr_en        = 1'b0;
        cnt_wr_addr      = cur_reg;
        cnt_wr_data      = cnt_q;
        link_wr_en       = 1'b0;
        link_wr_addr     = cur_reg;
        link_wr_data     = head_reg;
        kind_next        = kind_reg;
        idx_next         = idx_reg;
        idx_ok_next      = idx_ok_reg;
        cur_next         = cur_reg;
        cur_valid_next   = cur_valid_reg;
        pend_next        = pend_reg;
        head_next        = head_reg;
        fcnt_next        = fcnt_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_granted_next   = m_granted_reg;
        m_writer_next    = m_writer_reg;
        m_status_next    = m_status_reg;
        granted_wide     = {{rcbp_pkg::INDEX_W{1'b0}}, res_granted_reg};
        writer_wide      = {{rcbp_pkg::INDEX_W{1'b0}}, pend_reg};

        case (state_reg)
            rcbp_pkg::S_IDLE: begin
                s_ready     = 1'b1;
                mem_rd_en   = s_accept;
                kind_next   = s_kind;
                idx_next    = s_idx_wide[IDX_W-1:0];
                idx_ok_next = s_idx_wide < WIDE_W'(BUFFERS);
                if (s_kind == rcbp_pkg::KIND_RELEASE) begin
                    cnt_rd_addr = s_idx_wide[IDX_W-1:0];
                end
            end

            rcbp_pkg::S_EXEC: begin
                res_granted_next = '0;
                res_status_next  = rcbp_pkg::STATUS_OK;
                case (kind_reg)
                    rcbp_pkg::KIND_PUBLISH: begin
                        if (!pub_ok) begin
                            res_status_next = rcbp_pkg::STATUS_EMPTY;
                        end else begin
                            // Drop the publisher's reference on the old current buffer.
                            cnt_wr_en   = cur_valid_reg && cnt_q != '0;
                            cnt_wr_addr = cur_reg;
                            cnt_wr_data = cnt_q - 1'b1;
                            if (cur_valid_reg && cnt_q == rcbp_pkg::COUNT_W'(1)
                                    && stack_room) begin
                                // The freed buffer is pushed and popped straight back
                                // as the new writer buffer; the head stays put.
                                link_wr_en   = 1'b1;
                                link_wr_addr = cur_reg;
                                link_wr_data = head_reg;
                                pend_next    = cur_reg;
                            end else begin
                                pend_next = head_reg;
                                head_next = link_q;
                                fcnt_next = fcnt_reg - 1'b1;
                            end
                            cur_next         = pend_reg;
                            cur_valid_next   = 1'b1;
                            res_granted_next = pend_reg;
                        end
                    end
                    rcbp_pkg::KIND_ACQUIRE: begin
                        if (!cur_valid_reg) begin
                            res_status_next = rcbp_pkg::STATUS_NO_CURRENT;
                        end else if (cnt_q == rcbp_pkg::COUNT_MAX) begin
                            res_status_next = rcbp_pkg::STATUS_OVERFLOW;
                        end else begin
                            cnt_wr_en        = 1'b1;
                            cnt_wr_addr      = cur_reg;
                            cnt_wr_data      = cnt_q + 1'b1;
                            res_granted_next = cur_reg;
                        end
                    end
                    rcbp_pkg::KIND_RELEASE: begin
                        if (!idx_ok_reg || cnt_q == '0) begin
                            res_status_next = rcbp_pkg::STATUS_RELEASE_ZERO;
                        end else begin
                            cnt_wr_en   = 1'b1;
                            cnt_wr_addr = idx_reg;
                            cnt_wr_data = cnt_q - 1'b1;
                            if (cnt_q == rcbp_pkg::COUNT_W'(1) && stack_room) begin
                                link_wr_en   = 1'b1;
                                link_wr_addr = idx_reg;
                                link_wr_data = head_reg;
                                head_next    = idx_reg;
                                fcnt_next    = fcnt_reg + 1'b1;
                            end
                        end
                    end
                    default: begin
                        res_status_next = rcbp_pkg::STATUS_OK;
                    end
                endcase
            end

            rcbp_pkg::S_PUB_SET: begin
                // The new current buffer starts with the publisher's single reference.
                cnt_wr_en   = 1'b1;
                cnt_wr_addr = cur_reg;
                cnt_wr_data = rcbp_pkg::COUNT_W'(1);
            end

            rcbp_pkg::S_DONE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_granted_next = granted_wide[rcbp_pkg::INDEX_W-1:0];
                    m_writer_next  = writer_wide[rcbp_pkg::INDEX_W-1:0];
                    m_status_next  = res_status_reg;
                end
            end

            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rcbp_pkg::S_IDLE;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            pend_reg      <= '0;
            head_reg      <= IDX_W'(1);
            fcnt_reg      <= FCNT_W'(BUFFERS - 1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            pend_reg      <= pend_next;
            head_reg      <= head_next;
            fcnt_reg      <= fcnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        kind_reg        <= kind_next;
        idx_reg         <= idx_next;
        idx_ok_reg      <= idx_ok_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        m_granted_reg   <= m_granted_next;
        m_writer_reg    <= m_writer_next;
        m_status_reg    <= m_status_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_granted_buffer = m_granted_reg;
    assign m_writer_buffer  = m_writer_reg;
    assign m_status         = m_status_reg;

endmodule

`default_nettype wire

/* sim/refcounted_buffer_pool_test.sv */
// Self-checking testbench for the reference-counted buffer pool and its free stack.
`timescale 1ns / 1ps

module refcounted_buffer_pool_test;

    // Pool size under test. The index field is four bits wide, so sixteen buffers
    // cover every index the input channel can carry.
    localparam int BUFFERS = rcbp_pkg::DEF_BUFFERS;

    // The kind field has one code the block does not define. It must be answered
    // with an OK status and leave the pool untouched.
    localparam logic [rcbp_pkg::KIND_W-1:0] KIND_RESERVED = 2'd3;

    // A successful publish, the slowest transaction, reaches the output register well within the
    // drain, so the quiet at the end is ample to catch a stray result.
    localparam int DRAIN_CYCLES = 40;

    // The slowest correct run is roughly 1100 transactions, each with its random gaps and
    // stalls, plus one long receiver hold. This limit is several times that.
    localparam int LIMIT_NS = 800_000;

    // One result transaction, field by field.
    typedef struct packed {
        logic [rcbp_pkg::INDEX_W-1:0]  granted;
        logic [rcbp_pkg::INDEX_W-1:0]  writer;
        logic [rcbp_pkg::STATUS_W-1:0] status;
    } pool_result_t;

    logic                          aclk           = 1'b0;
    logic                          aresetn        = 1'b0;
    logic                          s_valid        = 1'b0;
    logic                          s_ready;
    logic [rcbp_pkg::KIND_W-1:0]   s_kind         = '0;
    logic [rcbp_pkg::INDEX_W-1:0]  s_buffer_index = '0;
    logic                          m_valid;
    logic                          m_ready        = 1'b0;
    logic [rcbp_pkg::INDEX_W-1:0]  m_granted_buffer;
    logic [rcbp_pkg::INDEX_W-1:0]  m_writer_buffer;
    logic [rcbp_pkg::STATUS_W-1:0] m_status;

    // Our own copy of the pool state. It advances exactly once per accepted input
    // transaction, at the clock edge where that transaction is accepted.
    logic [rcbp_pkg::COUNT_W-1:0] pool_refs  [BUFFERS];
    int                           pool_links [BUFFERS];
    int                           pool_head;
    int                           pool_free_count;
    int                           pool_current;
    bit                           pool_current_valid;
    int                           pool_writer;

    // Results predicted for accepted inputs and not yet seen on the output channel.
    pool_result_t pool_replies_due [$];

    int mismatch_count;

    // Idle behavior of both sides. The test tasks retune these as they go.
    int send_gap_max      = 12;
    int reply_stall_max   = 12;
    int reply_hold_cycles = 0;

    refcounted_buffer_pool #(
        .BUFFERS(BUFFERS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_buffer_index  (s_buffer_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted_buffer(m_granted_buffer),
        .m_writer_buffer (m_writer_buffer),
        .m_status        (m_status)
    );

    always #1 aclk = ~aclk;

    initial begin : watchdog
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Push a buffer on the free stack. A push onto a stack that already holds
    // every buffer is silently dropped.
    function automatic void free_push(input int b);
        if (pool_free_count >= BUFFERS) begin
            return;
        end
        pool_links[b % BUFFERS] = pool_head % BUFFERS;
        pool_head = b % BUFFERS;
        pool_free_count++;
    endfunction

    // Apply one input transaction to the pool state and return the result it causes.
    function automatic pool_result_t pool_apply(input logic [rcbp_pkg::KIND_W-1:0] op,
                                                input logic [rcbp_pkg::INDEX_W-1:0] idx);
        pool_result_t r;
        int           cur;
        bit           frees;
        int           avail;
        r.granted = '0;
        r.status  = rcbp_pkg::STATUS_OK;
        cur = pool_current % BUFFERS;
        case (op)
            rcbp_pkg::KIND_PUBLISH: begin
                // The old current buffer counts as available when this publish
                // drops its last reference.
                frees = pool_current_valid && pool_refs[cur] == 1;
                avail = pool_free_count + (frees ? 1 : 0);
                if (avail == 0) begin
                    r.status = rcbp_pkg::STATUS_EMPTY;
                end else begin
                    // A current buffer whose count was already released to zero
                    // is neither decremented nor pushed again.
                    if (pool_current_valid && pool_refs[cur] != 0) begin
                        pool_refs[cur]--;
                        if (pool_refs[cur] == 0) begin
                            free_push(cur);
                        end
                    end
                    pool_refs[pool_writer % BUFFERS] = 1;
                    pool_current       = pool_writer % BUFFERS;
                    pool_current_valid = 1'b1;
                    // Pop the next writer buffer off the free stack.
                    pool_writer = pool_head % BUFFERS;
                    pool_head   = pool_links[pool_writer] % BUFFERS;
                    pool_free_count--;
                    r.granted = pool_current[rcbp_pkg::INDEX_W-1:0];
                end
            end
            rcbp_pkg::KIND_ACQUIRE: begin
                if (!pool_current_valid) begin
                    r.status = rcbp_pkg::STATUS_NO_CURRENT;
                end else if (pool_refs[cur] == rcbp_pkg::COUNT_MAX) begin
                    r.status = rcbp_pkg::STATUS_OVERFLOW;
                end else begin
                    pool_refs[cur]++;
                    r.granted = cur[rcbp_pkg::INDEX_W-1:0];
                end
            end
            rcbp_pkg::KIND_RELEASE: begin
                if (idx >= BUFFERS || pool_refs[idx % BUFFERS] == 0) begin
                    r.status = rcbp_pkg::STATUS_RELEASE_ZERO;
                end else begin
                    pool_refs[idx % BUFFERS]--;
                    if (pool_refs[idx % BUFFERS] == 0) begin
                        free_push(idx % BUFFERS);
                    end
                end
            end
            default: begin
                // Reserved kind: nothing changes.
            end
        endcase
        r.writer = pool_writer[rcbp_pkg::INDEX_W-1:0];
        return r;
    endfunction

    // Offer one input transaction after a random gap and hold it until accepted.
    // The valid line is only lowered at the start of the next call, and only when
    // that call has a gap, so back-to-back transactions never toggle valid within
    // one time step. Callers must not let time pass between calls.
    task automatic send_op(input logic [rcbp_pkg::KIND_W-1:0] op,
                           input logic [rcbp_pkg::INDEX_W-1:0] idx);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= op;
        s_buffer_index <= idx;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        pool_replies_due.push_back(pool_apply(op, idx));
    endtask

    // Choose one transaction of mostly well-formed traffic. Releases mostly target
    // buffers that really hold references, so the pool cycles through allocation,
    // exhaustion and recovery instead of drowning in rejected releases.
    task automatic pick_traffic(output logic [rcbp_pkg::KIND_W-1:0] op,
                                output logic [rcbp_pkg::INDEX_W-1:0] idx);
        int roll;
        int start;
        int b;
        roll = $urandom_range(0, 99);
        idx  = rcbp_pkg::INDEX_W'($urandom_range(0, (1 << rcbp_pkg::INDEX_W) - 1));
        if (roll < 25) begin
            op = rcbp_pkg::KIND_PUBLISH;
        end else if (roll < 55) begin
            op = rcbp_pkg::KIND_ACQUIRE;
        end else if (roll < 85) begin
            op    = rcbp_pkg::KIND_RELEASE;
            start = $urandom_range(0, BUFFERS - 1);
            for (int k = 0; k < BUFFERS; k++) begin
                b = (start + k) % BUFFERS;
                if (pool_refs[b] != 0) begin
                    idx = b[rcbp_pkg::INDEX_W-1:0];
                    break;
                end
            end
        end else if (roll < 93) begin
            // Release of an arbitrary index, often one already at zero.
            op = rcbp_pkg::KIND_RELEASE;
        end else begin
            op = KIND_RESERVED;
        end
    endtask

    // Before anything is published: acquire has no current buffer, every release
    // hits a zero count, and the reserved kind is answered with OK.
    task automatic test_before_publish();
        send_op(rcbp_pkg::KIND_ACQUIRE, 4'hF);
        send_op(rcbp_pkg::KIND_RELEASE, 4'h0);
        send_op(rcbp_pkg::KIND_RELEASE, 4'hF);
        send_op(KIND_RESERVED, 4'hA);
        send_op(KIND_RESERVED, 4'h5);
        send_op(rcbp_pkg::KIND_ACQUIRE, 4'h0);
    endtask

    // The first publish drops no reference. Then plain acquire and release, and a
    // second publish that drops the publisher's reference on the old current buffer.
    task automatic test_first_publish();
        int first;
        send_op(rcbp_pkg::KIND_PUBLISH, 4'hF);
        first = pool_current;
        send_op(rcbp_pkg::KIND_ACQUIRE, 4'h0);
        send_op(rcbp_pkg::KIND_RELEASE, first[rcbp_pkg::INDEX_W-1:0]);
        send_op(rcbp_pkg::KIND_ACQUIRE, 4'h0);
        send_op(rcbp_pkg::KIND_PUBLISH, 4'h0);
        send_op(rcbp_pkg::KIND_RELEASE, first[rcbp_pkg::INDEX_W-1:0]);
        send_op(rcbp_pkg::KIND_RELEASE, first[rcbp_pkg::INDEX_W-1:0]);
    endtask

    // Release the current buffer down to zero; the next publish must then leave its
    // count alone and must not push it a second time.
    task automatic test_current_released();
        send_op(rcbp_pkg::KIND_RELEASE, pool_current[rcbp_pkg::INDEX_W-1:0]);
        send_op(rcbp_pkg::KIND_PUBLISH, 4'h3);
        send_op(rcbp_pkg::KIND_ACQUIRE, 4'hC);
        send_op(rcbp_pkg::KIND_RELEASE, pool_current[rcbp_pkg::INDEX_W-1:0]);
    endtask

    // Hold a reference on every published buffer until the free stack runs dry, try
    // a publish that must fail, then one that succeeds only because it frees the old
    // current buffer. Afterwards every reader reference is returned.
    task automatic test_empty_free_stack();
        for (int n = 0; n < BUFFERS && pool_free_count > 0; n++) begin
            send_op(rcbp_pkg::KIND_ACQUIRE, 4'h0);
            send_op(rcbp_pkg::KIND_PUBLISH, 4'h0);
        end
        send_op(rcbp_pkg::KIND_ACQUIRE, 4'h0);
        send_op(rcbp_pkg::KIND_PUBLISH, 4'h0);
        send_op(rcbp_pkg::KIND_RELEASE, pool_current[rcbp_pkg::INDEX_W-1:0]);
        send_op(rcbp_pkg::KIND_PUBLISH, 4'h0);
        for (int b = 0; b < BUFFERS; b++) begin
            while (b != pool_current && pool_refs[b] != 0) begin
                send_op(rcbp_pkg::KIND_RELEASE, b[rcbp_pkg::INDEX_W-1:0]);
            end
        end
    endtask

    // Drive the current buffer's count to its ceiling, overflow it once, and bring
    // it back down. Gaps stay short since this takes about five hundred transactions.
    task automatic test_count_overflow();
        send_gap_max    = 1;
        reply_stall_max = 1;
        while (pool_refs[pool_current] != rcbp_pkg::COUNT_MAX) begin
            send_op(rcbp_pkg::KIND_ACQUIRE, 4'h0);
        end
        send_op(rcbp_pkg::KIND_ACQUIRE, 4'hF);
        while (pool_refs[pool_current] > 1) begin
            send_op(rcbp_pkg::KIND_RELEASE, pool_current[rcbp_pkg::INDEX_W-1:0]);
        end
    endtask

    // The receiver stops taking results for a long stretch while the sender keeps
    // offering transactions back to back, so the block fills up and must stall its
    // input without losing or reordering anything.
    task automatic test_output_backpressure();
        logic [rcbp_pkg::KIND_W-1:0]  op;
        logic [rcbp_pkg::INDEX_W-1:0] idx;
        send_gap_max      = 0;
        reply_stall_max   = 0;
        reply_hold_cycles = 300;
        repeat (60) begin
            pick_traffic(op, idx);
            send_op(op, idx);
        end
    endtask

    // Random run in chunks, each with its own idle behavior on both sides, which can
    // include chunks where neither side idles at all.
    task automatic test_random_traffic();
        logic [rcbp_pkg::KIND_W-1:0]  op;
        logic [rcbp_pkg::INDEX_W-1:0] idx;
        int                           gap_levels [3] = '{0, 3, 12};
        for (int chunk = 0; chunk < 14; chunk++) begin
            send_gap_max    = gap_levels[$urandom_range(0, 2)];
            reply_stall_max = gap_levels[$urandom_range(0, 2)];
            repeat (30) begin
                pick_traffic(op, idx);
                send_op(op, idx);
            end
        end
    endtask

    // Result side: before each result, optionally a long hold requested by a test,
    // then a random stall, then ready stays high until a result is taken.
    initial begin : reply_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (reply_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (reply_hold_cycles) @(negedge aclk);
                reply_hold_cycles = 0;
            end
            stall = $urandom_range(0, reply_stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch in %s at %0t: expected %0d, got %0d", what, $time, want, got);
        end
    endtask

    // Every result transaction is checked against the oldest prediction.
    always @(posedge aclk) begin : check_results
        pool_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pool_replies_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("result at %0t with nothing outstanding", $time);
                end
            end else begin
                want = pool_replies_due.pop_front();
                if (m_granted_buffer !== want.granted) begin
                    note_mismatch("granted_buffer", 32'(want.granted), 32'(m_granted_buffer));
                end
                if (m_writer_buffer !== want.writer) begin
                    note_mismatch("writer_buffer", 32'(want.writer), 32'(m_writer_buffer));
                end
                if (m_status !== want.status) begin
                    note_mismatch("status", 32'(want.status), 32'(m_status));
                end
            end
        end
    end

    initial begin : run
        for (int b = 0; b < BUFFERS; b++) begin
            pool_refs[b]  = '0;
            pool_links[b] = (b + 1) % BUFFERS;
        end
        pool_head          = 1;
        pool_free_count    = BUFFERS - 1;
        pool_current       = 0;
        pool_current_valid = 1'b0;
        pool_writer        = 0;
        mismatch_count     = 0;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_before_publish();
        test_first_publish();
        test_current_released();
        test_empty_free_stack();
        test_count_overflow();
        test_output_backpressure();
        test_random_traffic();

        // Stop offering, let every outstanding result arrive, then watch for strays.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pool_replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
